// ===== design/saes_pkg.sv =====
// Shared types, constants and nibble functions for the simplified AES encryption block.
`default_nettype none

package saes_pkg;

  localparam int unsigned BLOCK_W = 16;
  localparam int unsigned KEY_W   = 16;
  localparam int unsigned WORD_W  = 8;

  localparam logic [WORD_W-1:0] RCON1 = 8'h80;
  localparam logic [WORD_W-1:0] RCON2 = 8'h30;
  localparam logic [4:0]        GF_POLY = 5'h13;

  typedef logic [BLOCK_W-1:0] block_t;
  typedef logic [WORD_W-1:0]  word_t;

  typedef struct packed {
    block_t k0;
    block_t k1;
    block_t k2;
  } saes_rkeys_t;

  function automatic logic [3:0] sbox(input logic [3:0] n);
    logic [3:0] r;
    unique case (n)
      4'h0: r = 4'h9;
      4'h1: r = 4'h4;
      4'h2: r = 4'ha;
      4'h3: r = 4'hb;
      4'h4: r = 4'hd;
      4'h5: r = 4'h1;
      4'h6: r = 4'h8;
      4'h7: r = 4'h5;
      4'h8: r = 4'h6;
      4'h9: r = 4'h2;
      4'ha: r = 4'h0;
      4'hb: r = 4'h3;
      4'hc: r = 4'hc;
      4'hd: r = 4'he;
      4'he: r = 4'hf;
      default: r = 4'h7;
    endcase
    return r;
  endfunction

  function automatic block_t nibble_sub(input block_t s);
    return {sbox(s[15:12]), sbox(s[11:8]), sbox(s[7:4]), sbox(s[3:0])};
  endfunction

  function automatic block_t shift_rows(input block_t s);
    return {s[15:12], s[3:0], s[7:4], s[11:8]};
  endfunction

  // Multiplication by x^2 in GF(16), two shift-and-reduce steps.
  function automatic logic [3:0] gf_mul4(input logic [3:0] n);
    logic [4:0] a;
    a = {1'b0, n};
    for (int i = 0; i < 2; i++) begin
      a = {a[3:0], 1'b0};
      if (a[4]) begin
        a = a ^ GF_POLY;
      end
    end
    return a[3:0];
  endfunction

  function automatic block_t mix_columns(input block_t s);
    return {s[15:12] ^ gf_mul4(s[11:8]), gf_mul4(s[15:12]) ^ s[11:8],
            s[7:4] ^ gf_mul4(s[3:0]), gf_mul4(s[7:4]) ^ s[3:0]};
  endfunction

  function automatic word_t key_g(input word_t w, input word_t rcon);
    return {sbox(w[3:0]), sbox(w[7:4])} ^ rcon;
  endfunction

endpackage

`default_nettype wire

// ===== design/saes_key_exp.sv =====
// Key expansion: derives the three round keys from the cipher key.
`default_nettype none

module saes_key_exp (
  input  wire saes_pkg::block_t      key,
  output saes_pkg::saes_rkeys_t      rkeys
);
  import saes_pkg::*;

  word_t w0, w1, w2, w3, w4, w5;

  always_comb begin
    w0 = key[15:8];
    w1 = key[7:0];
    w2 = w0 ^ key_g(w1, RCON1);
    w3 = w2 ^ w1;
    w4 = w2 ^ key_g(w3, RCON2);
    w5 = w4 ^ w3;
    rkeys.k0 = {w0, w1};
    rkeys.k1 = {w2, w3};
    rkeys.k2 = {w4, w5};
  end

endmodule

`default_nettype wire

// ===== design/saes_round1.sv =====
// First round stage: substitution, shift rows, mix columns and round key one, registered.
`default_nettype none

module saes_round1 (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  input  wire saes_pkg::block_t in_state,
  input  wire saes_pkg::block_t subkey,
  output logic                  out_valid,
  output saes_pkg::block_t      out_state
);
  import saes_pkg::*;

  logic   valid_r;
  block_t state_r, state_nxt;

  assign state_nxt = mix_columns(shift_rows(nibble_sub(in_state))) ^ subkey;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    state_r <= state_nxt;
  end

  assign out_valid = valid_r;
  assign out_state = state_r;

endmodule

`default_nettype wire

// ===== design/saes_round2.sv =====
// Final round stage: substitution, shift rows and round key two, registered.
`default_nettype none

module saes_round2 (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  input  wire saes_pkg::block_t in_state,
  input  wire saes_pkg::block_t subkey,
  output logic                  out_valid,
  output saes_pkg::block_t      out_state
);
  import saes_pkg::*;

  logic   valid_r;
  block_t state_r, state_nxt;

  assign state_nxt = shift_rows(nibble_sub(in_state)) ^ subkey;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    state_r <= state_nxt;
  end

  assign out_valid = valid_r;
  assign out_state = state_r;

endmodule

`default_nettype wire

// ===== design/simplified_aes_encrypt.sv =====
// Top level of the simplified AES encryption block, a three-stage pipeline.
//
// The key is written on the cfg channel (cfg_valid, cfg_ready, cfg_cipher_key),
// and its reset value is zero. The user must write it only while no item is in
// flight; the block does not enforce this. An item is accepted at a rising edge
// where start is high and busy is low. busy is low at all times outside reset,
// so one item can enter every cycle. Each item passes three register stages:
// the initial key addition, the first round with mix columns, and the final
// round. Its ciphertext appears on out_ciphertext from the final round register,
// marked by out_valid for exactly one cycle.
// Throughput is one item per cycle, set by the one-stage-per-round pipeline.
// The receiver cannot hold results off, so the pipeline never stalls.
// Synchronous reset clears the key and every valid bit, discarding items in
// flight; busy is high and cfg_ready low while reset is held.
`default_nettype none

module simplified_aes_encrypt (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   start,
  output logic                  busy,
  input  wire saes_pkg::block_t in_plaintext,
  output logic                  out_valid,
  output saes_pkg::block_t      out_ciphertext,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire saes_pkg::block_t cfg_cipher_key
);
  import saes_pkg::*;

  block_t      key_r;
  saes_rkeys_t rkeys;
  logic        accept;
  logic        v0_r;
  block_t      s0_r, s0_nxt;
  logic        v1;
  block_t      s1;

  assign busy      = !rst_n;
  assign cfg_ready = rst_n;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      key_r <= cfg_cipher_key;
    end
  end

  saes_key_exp u_key_exp (
    .key   (key_r),
    .rkeys (rkeys)
  );

  assign s0_nxt = in_plaintext ^ rkeys.k0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s0_r <= s0_nxt;
  end

  saes_round1 u_round1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v0_r),
    .in_state  (s0_r),
    .subkey    (rkeys.k1),
    .out_valid (v1),
    .out_state (s1)
  );

  saes_round2 u_round2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v1),
    .in_state  (s1),
    .subkey    (rkeys.k2),
    .out_valid (out_valid),
    .out_state (out_ciphertext)
  );

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid);

  a_reset_blocks_ports: assert property (@(posedge clk) !rst_n |-> busy && !cfg_ready);

  a_item_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##3 out_valid);

  a_no_spurious_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 3));

  a_key_holds: assert property (@(posedge clk)
    rst_n && !(cfg_valid && cfg_ready) |=> $stable(key_r));

endmodule

`default_nettype wire

// ===== dv/tb_simplified_aes_encrypt.sv =====
// Testbench for the simplified AES encryption block: predictor, scoreboard and stimulus.
module tb_simplified_aes_encrypt;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned N_PHASES    = 5;
  localparam int unsigned PHASE_ITEMS = 206;
  localparam bit [63:0]   SBOX_LUT    = 64'h7FEC_3026_581D_BA49;

  class ciphertext_board;
    saes_pkg::block_t key;
    saes_pkg::block_t awaited[$];
    int unsigned      errors;
    int unsigned      checked;

    function new();
      key     = '0;
      errors  = 0;
      checked = 0;
    endfunction

    function logic [3:0] sub_nib(input logic [3:0] n);
      return SBOX_LUT[n*4 +: 4];
    endfunction

    function logic [3:0] gf_times(input logic [3:0] a, input logic [3:0] b);
      logic [4:0] acc;
      logic [4:0] x;
      acc = '0;
      x   = {1'b0, a};
      for (int i = 0; i < 4; i++) begin
        if (b[i]) begin
          acc = acc ^ x;
        end
        x = {x[3:0], 1'b0};
        if (x[4]) begin
          x = x ^ saes_pkg::GF_POLY;
        end
      end
      return acc[3:0];
    endfunction

    function saes_pkg::block_t sub_block(input saes_pkg::block_t s);
      return {sub_nib(s[15:12]), sub_nib(s[11:8]), sub_nib(s[7:4]), sub_nib(s[3:0])};
    endfunction

    function saes_pkg::block_t swap_row(input saes_pkg::block_t s);
      return {s[15:12], s[3:0], s[7:4], s[11:8]};
    endfunction

    function saes_pkg::block_t mix_block(input saes_pkg::block_t s);
      return {s[15:12] ^ gf_times(4'h4, s[11:8]), gf_times(4'h4, s[15:12]) ^ s[11:8],
              s[7:4] ^ gf_times(4'h4, s[3:0]), gf_times(4'h4, s[7:4]) ^ s[3:0]};
    endfunction

    function saes_pkg::word_t key_word_g(input saes_pkg::word_t w,
                                         input saes_pkg::word_t rc);
      return {sub_nib(w[3:0]), sub_nib(w[7:4])} ^ rc;
    endfunction

    function saes_pkg::block_t encrypt(input saes_pkg::block_t p);
      saes_pkg::word_t  w0, w1, w2, w3, w4, w5;
      saes_pkg::block_t s;
      w0 = key[15:8];
      w1 = key[7:0];
      w2 = w0 ^ key_word_g(w1, saes_pkg::RCON1);
      w3 = w2 ^ w1;
      w4 = w2 ^ key_word_g(w3, saes_pkg::RCON2);
      w5 = w4 ^ w3;
      s = p ^ {w0, w1};
      s = mix_block(swap_row(sub_block(s))) ^ {w2, w3};
      s = swap_row(sub_block(s)) ^ {w4, w5};
      return s;
    endfunction

    function void note_plaintext(input saes_pkg::block_t p);
      awaited.push_back(encrypt(p));
    endfunction

    function void check_ciphertext(input saes_pkg::block_t c);
      saes_pkg::block_t want;
      if (awaited.size() == 0) begin
        $error("ciphertext: unexpected result, expected none, actual %h", c);
        errors++;
      end else begin
        want = awaited.pop_front();
        checked++;
        if (c !== want) begin
          $error("ciphertext: expected %h, actual %h", want, c);
          errors++;
        end
      end
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  saes_pkg::block_t in_plaintext;
  logic             out_valid;
  saes_pkg::block_t out_ciphertext;
  logic             cfg_valid;
  logic             cfg_ready;
  saes_pkg::block_t cfg_cipher_key;

  ciphertext_board board;
  int unsigned     quiet_cycles;
  int unsigned     items_sent;
  int unsigned     key_writes;

  simplified_aes_encrypt i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_plaintext  (in_plaintext),
    .out_valid     (out_valid),
    .out_ciphertext(out_ciphertext),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_cipher_key(cfg_cipher_key)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid || (cfg_valid && cfg_ready) || (start && !busy)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (out_valid) begin
        board.check_ciphertext(out_ciphertext);
      end
      if (cfg_valid && cfg_ready) begin
        board.key = cfg_cipher_key;
      end
      if (start && !busy) begin
        board.note_plaintext(in_plaintext);
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic send_plaintext(input saes_pkg::block_t p, input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      in_plaintext = saes_pkg::block_t'($urandom);
      @(negedge clk);
    end
    start = 1'b1;
    in_plaintext = p;
    do @(posedge clk); while (busy);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic drain_pipeline();
    start = 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_key(input saes_pkg::block_t k);
    drain_pipeline();
    cfg_cipher_key = k;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_cipher_key = saes_pkg::block_t'($urandom);
    key_writes++;
  endtask

  function automatic saes_pkg::block_t pick_plaintext();
    case ($urandom_range(15))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return saes_pkg::block_t'(16'h1 << $urandom_range(15));
      3: return ~saes_pkg::block_t'(16'h1 << $urandom_range(15));
      default: return saes_pkg::block_t'($urandom_range(65535));
    endcase
  endfunction

  initial begin
    int unsigned      idle_plan [N_PHASES];
    saes_pkg::block_t key_plan  [N_PHASES];
    int unsigned      pause_at;

    board          = new();
    quiet_cycles   = 0;
    items_sent     = 0;
    key_writes     = 0;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_plaintext   = '0;
    cfg_valid      = 1'b0;
    cfg_cipher_key = '0;
    idle_plan = '{0, 68, 14, 68, 0};
    key_plan  = '{16'hFFFF, saes_pkg::block_t'($urandom), 16'h0000,
                  saes_pkg::block_t'($urandom), saes_pkg::block_t'($urandom)};

    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // The reset key of zero is used first, with the extremes of the block.
    send_plaintext(16'h0000, 0);
    send_plaintext(16'hFFFF, 0);
    send_plaintext(16'h0001, 0);
    send_plaintext(16'h8000, 0);
    send_plaintext(16'h00FF, 0);
    send_plaintext(16'hFF00, 0);
    send_plaintext(16'hAAAA, 0);
    send_plaintext(16'h5555, 0);
    send_plaintext(16'h0F0F, 0);
    send_plaintext(16'hF0F0, 0);
    load_key(16'h4AF5);
    send_plaintext(16'hD728, 0);
    send_plaintext(16'h0000, 0);
    send_plaintext(16'hFFFF, 0);
    load_key(16'hFFFF);
    send_plaintext(16'h0000, 0);
    send_plaintext(16'hFFFF, 0);
    send_plaintext(16'h1234, 0);
    load_key(16'h8001);
    send_plaintext(16'h7FFE, 0);
    send_plaintext(16'h8001, 0);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      load_key(key_plan[ph]);
      pause_at = $urandom_range(PHASE_ITEMS - 1, 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == pause_at) begin
          drain_pipeline();
        end
        send_plaintext(pick_plaintext(), idle_plan[ph]);
      end
    end

    start = 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Encrypted %0d blocks under %0d written keys plus the reset key.",
             items_sent, key_writes);
    $display("%0d results were checked against the predictor.", board.checked);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
